// File: hw/rtl/zcwd_pkg.sv
// Shared types and constants of the zero-crossing window detector.
package zcwd_pkg;

  typedef logic [23:0] pixel_t;

  // Register indexes on the configuration port
  localparam logic [2:0] REG_WIDTH     = 3'd0;
  localparam logic [2:0] REG_HEIGHT    = 3'd1;
  localparam logic [2:0] REG_HALF      = 3'd2;
  localparam logic [2:0] REG_THRESHOLD = 3'd3;
  localparam logic [2:0] REG_MODE      = 3'd4;

  // Edge channel codes
  localparam logic [1:0] CH_NONE  = 2'd0;
  localparam logic [1:0] CH_RED   = 2'd1;
  localparam logic [1:0] CH_GREEN = 2'd2;
  localparam logic [1:0] CH_BLUE  = 2'd3;

  localparam int unsigned MID_LEVEL    = 128;
  localparam int unsigned HEIGHT_LIMIT = 2044;

  typedef struct packed {
    logic [7:0] value;
    logic [1:0] channel;
    logic       last;
  } result_t;

endpackage

// File: hw/rtl/zero_crossing_window_detector.sv
// Zero-crossing edge detector over a LoG pixel stream, line store and window.
//
// Input channel (in_valid / in_stall): one word per pixel or pad item in raster
// order over a grid of (width + half) columns by (height + half) rows; items
// past the image edge carry pad_item = 1. A word whose pad flag does not fit
// the current grid position is taken and dropped.
// Output channel (out_valid / out_stall): one result word per image pixel,
// last_of_frame marks pixel (width-1, height-1). The result for pixel (x, y)
// comes from the item at grid position (x+half, y+half).
// Configuration (cfg_valid / cfg_ready): always ready; write only while idle.
// Throughput: one item per clock while in_stall is low. The line store is a single
// memory holding all stored lines of one column in one word; each item reads
// that word and writes its own lane in the same cycle, so neighbors never collide.
// Pipeline: the memory is read at the accepting edge, then the window shift,
// the row min/max, and the fold and compare into the output register are each
// registered in turn.
// Stall: a two-entry output (register plus skid) keeps the pipeline moving;
// in_stall rises only when the skid holds a word, and freezes all stages.
// Reset: counters, window and control clear; the line store is not cleared.
module zero_crossing_window_detector #(
  parameter int MAX_WINDOW = 7,
  parameter int MAX_WIDTH  = 1024
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  red_or_gray,
  input  logic [7:0]  green_value,
  input  logic [7:0]  blue_value,
  input  logic        pad_item,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  edge_value,
  output logic [1:0]  edge_channel,
  output logic        last_of_frame,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [10:0] cfg_data
);

  localparam int HALF_LIMIT = (MAX_WINDOW - 1) / 2;
  // the half register is two bits wide
  localparam int HMAX = (HALF_LIMIT > 3) ? 3 : HALF_LIMIT;
  localparam int SIDE = 2 * HMAX + 1;
  localparam int LN   = (HMAX > 0) ? 2 * HMAX : 2;
  localparam int SW   = $clog2(LN);
  localparam int KW   = (SIDE > 1) ? $clog2(SIDE) : 1;
  localparam int AW   = $clog2(MAX_WIDTH);
  localparam int CW   = $clog2(MAX_WIDTH + HMAX + 1);
  localparam int XW   = (CW > 11) ? CW : 11;

  // ---------------- configuration ----------------
  logic [10:0] cfg_w, cfg_hgt;
  logic [1:0]  cfg_half;
  logic [7:0]  cfg_thr;
  logic        cfg_mode;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_w    <= 11'd640;
      cfg_hgt  <= 11'd480;
      cfg_half <= 2'd1;
      cfg_thr  <= 8'd10;
      cfg_mode <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        zcwd_pkg::REG_WIDTH:     cfg_w    <= cfg_data;
        zcwd_pkg::REG_HEIGHT:    cfg_hgt  <= cfg_data;
        zcwd_pkg::REG_HALF:      cfg_half <= cfg_data[1:0];
        zcwd_pkg::REG_THRESHOLD: cfg_thr  <= cfg_data[7:0];
        zcwd_pkg::REG_MODE:      cfg_mode <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // effective geometry
  logic [XW-1:0] weff, w_ext;
  logic [10:0]   heff;
  logic [1:0]    h_eff;
  logic [2:0]    nl, side;
  logic [KW-1:0] side_m1, h_idx;

  always_comb begin
    w_ext = XW'(cfg_w);
    if (cfg_w == 11'd0) weff = XW'(1);
    else if (w_ext > XW'(MAX_WIDTH)) weff = XW'(MAX_WIDTH);
    else weff = w_ext;
    if (cfg_hgt == 11'd0) heff = 11'd1;
    else if (cfg_hgt > 11'(zcwd_pkg::HEIGHT_LIMIT)) heff = 11'(zcwd_pkg::HEIGHT_LIMIT);
    else heff = cfg_hgt;
    h_eff   = (cfg_half > 2'(HMAX)) ? 2'(HMAX) : cfg_half;
    nl      = {h_eff, 1'b0};
    side    = {h_eff, 1'b1};
    side_m1 = KW'(nl);
    h_idx   = KW'(h_eff);
  end

  // ---------------- stage 0: grid position, line store access ----------------
  logic [XW-1:0] column_count;
  logic [10:0]   row_count;
  logic          en, in_take, take, pad_pos, c_in;
  logic          res_c, last_c;
  logic [XW-1:0] c_m, c_next_raw;
  logic [10:0]   r_m;
  logic [11:0]   r_next_raw;
  logic [2:0]    rmod;
  logic [19:0]   prod3;
  logic [8:0]    q3;
  logic [9:0]    rem3_full;
  logic          use_c [SIDE];
  logic [SW-1:0] slot_c [SIDE];
  logic signed [12:0] t_k, rr_k, hlast;
  logic [12:0]   d_full;
  logic [2:0]    d_k;
  logic [3:0]    sl_k;
  zcwd_pkg::pixel_t pix;

  assign en      = !in_stall;
  assign in_take = in_valid && !in_stall;
  assign pix     = {blue_value, green_value, red_or_gray};

  always_comb begin
    pad_pos = (column_count >= weff) || (row_count >= heff);
    c_in    = column_count < weff;
    take    = in_take && (pad_item == pad_pos);
    c_m     = column_count - XW'(h_eff);
    r_m     = row_count - 11'(h_eff);
    res_c   = (column_count >= XW'(h_eff)) && (row_count >= 11'(h_eff))
              && (c_m < weff) && (r_m < heff);
    last_c  = (c_m == weff - XW'(1)) && (r_m == heff - 11'd1);
    c_next_raw = column_count + XW'(1);
    r_next_raw = {1'b0, row_count} + 12'd1;

    // row mod 6 = 2 * ((row >> 1) mod 3) + row[0]
    prod3     = 20'(row_count[10:1]) * 20'd683;
    q3        = prod3[19:11];
    rem3_full = row_count[10:1] - ({1'b0, q3} + {q3, 1'b0});
    case (nl)
      3'd2:    rmod = {2'b00, row_count[0]};
      3'd4:    rmod = {1'b0, row_count[1:0]};
      3'd6:    rmod = {rem3_full[1:0], row_count[0]};
      default: rmod = 3'd0;
    endcase

    hlast = $signed({2'b00, heff - 11'd1});
    t_k = '0; rr_k = '0; d_full = '0; d_k = '0; sl_k = '0;
    for (int k = 0; k < SIDE; k++) begin
      t_k = $signed(13'({2'b00, row_count}) - 13'(nl) + 13'(k));
      if (t_k < 0) rr_k = '0;
      else if (t_k > hlast) rr_k = hlast;
      else rr_k = t_k;
      d_full = 13'({2'b00, row_count}) - 13'(rr_k);
      d_k    = d_full[2:0];
      use_c[k] = (d_k == 3'd0) || (nl == 3'd0);
      if (rmod >= d_k) sl_k = {1'b0, rmod - d_k};
      else sl_k = {1'b0, rmod} + {1'b0, nl} - {1'b0, d_k};
      slot_c[k] = SW'(sl_k);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      column_count <= '0;
      row_count    <= '0;
    end else if (take) begin
      if (c_next_raw >= weff + XW'(h_eff)) begin
        column_count <= '0;
        if (r_next_raw >= {1'b0, heff} + 12'(h_eff)) row_count <= '0;
        else row_count <= r_next_raw[10:0];
      end else begin
        column_count <= c_next_raw;
      end
    end
  end

  // line store: one word per column, one lane per stored line
  logic [LN-1:0][23:0] line_store [MAX_WIDTH];
  logic [LN-1:0][23:0] rdata;
  logic [AW-1:0]       addr;

  assign addr = column_count[AW-1:0];

  always_ff @(posedge clk) begin
    if (take) begin
      rdata <= line_store[addr];
      if (c_in && (row_count < heff) && (nl != 3'd0))
        line_store[addr][rmod[SW-1:0]] <= pix;
    end
  end

  // stage 1 inputs
  logic             s1_valid, s1_cin, s1_cz, s1_res, s1_last;
  zcwd_pkg::pixel_t s1_pix;
  logic             s1_use [SIDE];
  logic [SW-1:0]    s1_slot [SIDE];

  always_ff @(posedge clk) begin
    if (rst) s1_valid <= 1'b0;
    else if (en) s1_valid <= take;
  end

  always_ff @(posedge clk) begin
    if (take) begin
      s1_pix  <= pix;
      s1_cin  <= c_in;
      s1_cz   <= column_count == '0;
      s1_res  <= res_c;
      s1_last <= last_c;
      for (int k = 0; k < SIDE; k++) begin
        s1_use[k]  <= use_c[k];
        s1_slot[k] <= slot_c[k];
      end
    end
  end

  // ---------------- stage 1: window shift ----------------
  zcwd_pkg::pixel_t win [SIDE][SIDE];
  zcwd_pkg::pixel_t col [SIDE];
  logic             s2_valid, s2_last;

  always_comb begin
    for (int k = 0; k < SIDE; k++) begin
      if (!s1_cin) col[k] = win[k][side_m1];
      else if (s1_use[k]) col[k] = s1_pix;
      else col[k] = rdata[s1_slot[k]];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < SIDE; k++)
        for (int j = 0; j < SIDE; j++) win[k][j] <= '0;
    end else if (en && s1_valid) begin
      for (int k = 0; k < SIDE; k++) begin
        if (k < int'(side)) begin
          for (int j = 0; j < SIDE; j++) begin
            if (s1_cz) begin
              if (j < int'(side)) win[k][j] <= col[k];
            end else if (j + 1 < int'(side)) begin
              win[k][j] <= win[k][j + 1];
            end else if (j + 1 == int'(side)) begin
              win[k][j] <= col[k];
            end
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) s2_valid <= 1'b0;
    else if (en) s2_valid <= s1_valid && s1_res;
  end

  always_ff @(posedge clk) begin
    if (en) s2_last <= s1_last;
  end

  // ---------------- stage 2: per-row min and max ----------------
  logic [7:0]       row_min [SIDE][3];
  logic [7:0]       row_max [SIDE][3];
  logic [7:0]       s3_min [SIDE][3];
  logic [7:0]       s3_max [SIDE][3];
  zcwd_pkg::pixel_t s3_center;
  logic             s3_valid, s3_last;
  logic [7:0]       v;

  always_comb begin
    v = '0;
    for (int k = 0; k < SIDE; k++) begin
      for (int ch = 0; ch < 3; ch++) begin
        row_min[k][ch] = 8'hFF;
        row_max[k][ch] = 8'h00;
        if (k < int'(side)) begin
          for (int j = 0; j < SIDE; j++) begin
            v = win[k][j][8*ch +: 8];
            if (j < int'(side)) begin
              if (v < row_min[k][ch]) row_min[k][ch] = v;
              if (v > row_max[k][ch]) row_max[k][ch] = v;
            end
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) s3_valid <= 1'b0;
    else if (en) s3_valid <= s2_valid;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s3_min    <= row_min;
      s3_max    <= row_max;
      s3_center <= win[h_idx][h_idx];
      s3_last   <= s2_last;
    end
  end

  // ---------------- stage 3: fold rows, test band, select ----------------
  logic [7:0]        lo [3];
  logic [7:0]        hi [3];
  logic              is_edge [3];
  zcwd_pkg::result_t res;

  always_comb begin
    for (int ch = 0; ch < 3; ch++) begin
      lo[ch] = 8'hFF;
      hi[ch] = 8'h00;
      for (int k = 0; k < SIDE; k++) begin
        if (s3_min[k][ch] < lo[ch]) lo[ch] = s3_min[k][ch];
        if (s3_max[k][ch] > hi[ch]) hi[ch] = s3_max[k][ch];
      end
      // lo < 128 - thr and hi > 128 + thr
      is_edge[ch] = ({1'b0, lo[ch]} + {1'b0, cfg_thr} < 9'(zcwd_pkg::MID_LEVEL))
                    && ({2'b00, hi[ch]} > 10'(zcwd_pkg::MID_LEVEL) + {2'b00, cfg_thr});
    end
    res.last = s3_last;
    if (is_edge[0]) begin
      res.value   = s3_center[7:0];
      res.channel = zcwd_pkg::CH_RED;
    end else if (cfg_mode && is_edge[1]) begin
      res.value   = s3_center[15:8];
      res.channel = zcwd_pkg::CH_GREEN;
    end else if (cfg_mode && is_edge[2]) begin
      res.value   = s3_center[23:16];
      res.channel = zcwd_pkg::CH_BLUE;
    end else begin
      res.value   = 8'd0;
      res.channel = zcwd_pkg::CH_NONE;
    end
  end

  // ---------------- output register and skid ----------------
  zcwd_pkg::result_t out_word, skid_word;
  logic              skid_full, out_take;

  assign out_take      = out_valid && !out_stall;
  assign in_stall      = skid_full;
  assign edge_value    = out_word.value;
  assign edge_channel  = out_word.channel;
  assign last_of_frame = out_word.last;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      skid_full <= 1'b0;
    end else if (skid_full) begin
      if (out_take) begin
        out_word  <= skid_word;
        skid_full <= 1'b0;
      end
    end else if (s3_valid) begin
      if (!out_valid || out_take) begin
        out_word  <= res;
        out_valid <= 1'b1;
      end else begin
        skid_word <= res;
        skid_full <= 1'b1;
      end
    end else if (out_take) begin
      out_valid <= 1'b0;
    end
  end

endmodule

// File: test/zcwd_checker.sv
// Predictor and result checker for the zero-crossing window detector.
module zcwd_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [7:0]  red_or_gray,
  input  logic [7:0]  green_value,
  input  logic [7:0]  blue_value,
  input  logic        pad_item,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [7:0]  edge_value,
  input  logic [1:0]  edge_channel,
  input  logic        last_of_frame,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [10:0] cfg_data,
  output int          mismatch_count,
  output int          results_waiting,
  output int          results_checked,
  output int          edges_seen
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned WIN_MAX    = 7;
  localparam int unsigned WIDTH_MAX  = 1024;
  localparam int unsigned HALF_MAX   = (WIN_MAX - 1) / 2;
  localparam int unsigned LINE_SLOTS = WIN_MAX;

  logic [10:0] width_reg, height_reg;
  logic [1:0]  half_reg;
  logic [7:0]  thresh_reg;
  logic        rgb_mode;

  zcwd_pkg::pixel_t  line_mem [LINE_SLOTS * WIDTH_MAX];
  zcwd_pkg::pixel_t  win [WIN_MAX][WIN_MAX];
  int unsigned       col_pos, row_pos;
  zcwd_pkg::result_t edge_fifo [$];

  assign results_waiting = edge_fifo.size();

  function automatic bit lane_edge(int unsigned side, int unsigned sh);
    int lo, hi, v;
    lo = 255;
    hi = 0;
    for (int unsigned k = 0; k < side; k++)
      for (int unsigned j = 0; j < side; j++) begin
        v = int'(win[k][j][sh +: 8]);
        if (v < lo) lo = v;
        if (v > hi) hi = v;
      end
    return (lo < int'(zcwd_pkg::MID_LEVEL) - int'(thresh_reg)) &&
           (hi > int'(zcwd_pkg::MID_LEVEL) + int'(thresh_reg));
  endfunction

  // Advances the window by one word; returns 1 when a pixel result is due.
  function automatic bit window_step(input zcwd_pkg::pixel_t pix, input bit pad_in,
                                     output zcwd_pkg::result_t res);
    int unsigned w, hg, hh, side, nl, c, r;
    int rr;
    zcwd_pkg::pixel_t colv [WIN_MAX];
    zcwd_pkg::pixel_t center;
    bit due;
    w = width_reg;   if (w < 1) w = 1;  if (w > WIDTH_MAX) w = WIDTH_MAX;
    hg = height_reg; if (hg < 1) hg = 1;
    if (hg > zcwd_pkg::HEIGHT_LIMIT) hg = zcwd_pkg::HEIGHT_LIMIT;
    hh = half_reg;   if (hh > HALF_MAX) hh = HALF_MAX;
    side = 2 * hh + 1;
    nl = 2 * hh;
    c = col_pos;
    r = row_pos;
    res = '0;
    due = 0;
    // wrong kind of word for this grid position: dropped
    if (pad_in != ((c >= w) || (r >= hg))) return 0;
    if (c < w) begin
      for (int unsigned k = 0; k < side; k++) begin
        rr = int'(r) - int'(nl) + int'(k);
        if (rr < 0) rr = 0;
        if (rr > int'(hg) - 1) rr = int'(hg) - 1;
        if (rr == int'(r) || nl == 0) colv[k] = pix;
        else colv[k] = line_mem[((rr % nl) % LINE_SLOTS) * WIDTH_MAX + c];
      end
      if (r < hg && nl > 0) line_mem[((r % nl) % LINE_SLOTS) * WIDTH_MAX + c] = pix;
    end else begin
      for (int unsigned k = 0; k < side; k++) colv[k] = win[k][side - 1];
    end
    for (int unsigned k = 0; k < side; k++) begin
      if (c == 0) begin
        for (int unsigned j = 0; j < side; j++) win[k][j] = colv[k];
      end else begin
        for (int unsigned j = 0; j + 1 < side; j++) win[k][j] = win[k][j + 1];
        win[k][side - 1] = colv[k];
      end
    end
    if (c >= hh && r >= hh && c - hh < w && r - hh < hg) begin
      center = win[hh][hh];
      res.channel = zcwd_pkg::CH_NONE;
      if (lane_edge(side, 0)) begin
        res.value = center[7:0];   res.channel = zcwd_pkg::CH_RED;
      end else if (rgb_mode && lane_edge(side, 8)) begin
        res.value = center[15:8];  res.channel = zcwd_pkg::CH_GREEN;
      end else if (rgb_mode && lane_edge(side, 16)) begin
        res.value = center[23:16]; res.channel = zcwd_pkg::CH_BLUE;
      end
      res.last = (c - hh == w - 1) && (r - hh == hg - 1);
      due = 1;
    end
    c++;
    if (c >= w + hh) begin
      c = 0;
      r++;
      if (r >= hg + hh) r = 0;
    end
    col_pos = c;
    row_pos = r;
    return due;
  endfunction

  always @(posedge clk) begin
    zcwd_pkg::result_t exp_res, got;
    bit due;
    if (rst) begin
      width_reg = 11'd640; height_reg = 11'd480; half_reg = 2'd1;
      thresh_reg = 8'd10;  rgb_mode = 1'b0;
      for (int i = 0; i < LINE_SLOTS * WIDTH_MAX; i++) line_mem[i] = '0;
      for (int k = 0; k < WIN_MAX; k++)
        for (int j = 0; j < WIN_MAX; j++) win[k][j] = '0;
      col_pos = 0;
      row_pos = 0;
      edge_fifo.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          zcwd_pkg::REG_WIDTH:     width_reg  = cfg_data;
          zcwd_pkg::REG_HEIGHT:    height_reg = cfg_data;
          zcwd_pkg::REG_HALF:      half_reg   = cfg_data[1:0];
          zcwd_pkg::REG_THRESHOLD: thresh_reg = cfg_data[7:0];
          zcwd_pkg::REG_MODE:      rgb_mode   = cfg_data[0];
          default: ;
        endcase
      end
      if (in_valid && !in_stall) begin
        due = window_step({blue_value, green_value, red_or_gray}, pad_item, exp_res);
        if (due) edge_fifo.push_back(exp_res);
      end
      if (out_valid && !out_stall) begin
        got = '{value: edge_value, channel: edge_channel, last: last_of_frame};
        results_checked++;
        if (edge_channel != zcwd_pkg::CH_NONE) edges_seen++;
        if (edge_fifo.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("[%0t] unexpected result word: value=%0d ch=%0d last=%0b",
                     $realtime, got.value, got.channel, got.last);
        end else begin
          exp_res = edge_fifo.pop_front();
          if (got.value !== exp_res.value || got.channel !== exp_res.channel ||
              got.last !== exp_res.last) begin
            mismatch_count++;
            if (mismatch_count <= 10)
              $display({"[%0t] result mismatch: exp value=%0d ch=%0d last=%0b, ",
                        "got value=%0d ch=%0d last=%0b"},
                       $realtime, exp_res.value, exp_res.channel, exp_res.last,
                       got.value, got.channel, got.last);
          end
        end
      end
    end
  end

  initial begin
    mismatch_count = 0;
    results_checked = 0;
    edges_seen = 0;
  end

endmodule

// File: test/tb_top.sv
// Stimulus, clock, reset and verdict for the zero-crossing window detector.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  red_or_gray = '0, green_value = '0, blue_value = '0;
  logic        pad_item = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [7:0]  edge_value;
  logic [1:0]  edge_channel;
  logic        last_of_frame;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [2:0]  cfg_index = '0;
  logic [10:0] cfg_data = '0;

  int mismatch_count, results_waiting, results_checked, edges_seen;

  // sender pacing: words left in the current burst, and the quiet flag
  // that turns gaps off for a whole frame
  int  burst_left = 0;
  bit  no_gaps = 0;
  int  words_sent = 0;
  int  frames_sent = 0;
  // per-frame value style: 0 uniform, 1 near mid level, 2 rails only
  int  value_style = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  zero_crossing_window_detector u_top (.*);

  zcwd_checker u_chk (.*);

  // Receiver stall: pattern switches at random between free-running, light, heavy and periodic.
  int stall_mode = 0, stall_left = 0, stall_tick = 0;
  always @(posedge clk) begin
    if (stall_left == 0) begin
      stall_mode <= $urandom_range(3);
      stall_left <= $urandom_range(80, 5);
    end else begin
      stall_left <= stall_left - 1;
    end
    stall_tick <= stall_tick + 1;
    case (stall_mode)
      0: out_stall <= 1'b0;
      1: out_stall <= ($urandom_range(99) < 25);
      2: out_stall <= ($urandom_range(99) < 75);
      default: out_stall <= (stall_tick % 4 == 0);
    endcase
  end

  function automatic logic [7:0] pick_value();
    case (value_style)
      1: return 8'($urandom_range(160, 96));
      2: return $urandom_range(1) ? 8'hFF : 8'h00;
      default: return 8'($urandom);
    endcase
  endfunction

  // One input word, held until the block takes it.
  task automatic send_word(input logic [7:0] r, g, b, input logic pad);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(40, 1);
      gap = no_gaps ? 0 : $urandom_range(8);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid    <= 1'b1;
    red_or_gray <= r;
    green_value <= g;
    blue_value  <= b;
    pad_item    <= pad;
    do @(posedge clk); while (in_stall);
    words_sent++;
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [10:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // Block must be drained before any register write. The first edges let
  // the checker log the last accepted word before the queue is polled.
  task automatic wait_idle();
    in_valid <= 1'b0;
    repeat (2) @(posedge clk);
    while (results_waiting != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic setup(input int w, hgt, half, thr, input bit rgb);
    wait_idle();
    write_reg(zcwd_pkg::REG_WIDTH, 11'(w));
    write_reg(zcwd_pkg::REG_HEIGHT, 11'(hgt));
    write_reg(zcwd_pkg::REG_HALF, 11'(half));
    write_reg(zcwd_pkg::REG_THRESHOLD, 11'(thr));
    write_reg(zcwd_pkg::REG_MODE, 11'(rgb));
  endtask

  // One full frame: image words plus the pad words that flush the window.
  // noise_pct adds words of the wrong kind, which the block must drop.
  task automatic send_frame(input int w, hgt, half, noise_pct);
    int ew, eh, eh_half;
    bit pad;
    ew = (w < 1) ? 1 : (w > 1024 ? 1024 : w);
    eh = (hgt < 1) ? 1 : (hgt > zcwd_pkg::HEIGHT_LIMIT ? zcwd_pkg::HEIGHT_LIMIT : hgt);
    eh_half = half;
    no_gaps = ($urandom_range(3) == 0);
    for (int y = 0; y < eh + eh_half; y++)
      for (int x = 0; x < ew + eh_half; x++) begin
        pad = (x >= ew) || (y >= eh);
        if ($urandom_range(99) < noise_pct)
          send_word(8'($urandom), 8'($urandom), 8'($urandom), !pad);
        send_word(pick_value(), pick_value(), pick_value(), pad);
      end
    frames_sent++;
  endtask

  initial begin
    int w, hgt, half, thr;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: unused register indexes, then tiny frames at the corners
    write_reg(3'd5, 11'h7FF);
    write_reg(3'd7, 11'h000);
    setup(2, 2, 0, 0, 0);        // single-pixel window never spans the band
    value_style = 2;
    send_frame(2, 2, 0, 20);
    setup(3, 2, 1, 0, 1);        // rails in RGB, zero threshold
    send_frame(3, 2, 1, 0);
    setup(1, 1, 3, 255, 1);      // widest window on a one-pixel image
    send_frame(1, 1, 3, 0);
    setup(0, 0, 2, 127, 0);      // zero sizes act as one
    value_style = 1;
    send_frame(0, 0, 2, 0);

    // Size extreme: one full-width row
    value_style = 0;
    setup(2047, 1, 0, 0, 0);     // oversize width clamps to the maximum
    send_frame(2047, 1, 0, 0);

    // Random frames, mostly small, until the word budget is used
    while (words_sent < 1500) begin
      w = $urandom_range(10, 1);
      hgt = $urandom_range(6, 1);
      half = $urandom_range(3);
      case ($urandom_range(3))
        0: thr = 0;
        1: thr = 255;
        2: thr = $urandom_range(30);
        default: thr = $urandom_range(255);
      endcase
      value_style = $urandom_range(2);
      setup(w, hgt, half, thr, $urandom_range(1));
      send_frame(w, hgt, half, ($urandom_range(4) == 0) ? 10 : 0);
    end

    wait_idle();
    repeat (20) @(posedge clk);
    $display("Sent %0d frames; %0d result words checked, %0d flagged as edges.",
             frames_sent, results_checked, edges_seen);
    if (mismatch_count == 0 && results_waiting == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // Watchdog
  initial begin
    #20ms;
    $display("Timeout with %0d results still expected", results_waiting);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
